>>> rtl/tdc_pkg.sv
// shared types, codes and text helpers for the time-of-day counter
`timescale 1ns / 1ps

package tdc_pkg;

  // command codes carried by an input word
  typedef enum logic [2:0] {
    CMD_TICK     = 3'd0,
    CMD_ADV_H    = 3'd1,
    CMD_ADV_M    = 3'd2,
    CMD_ADV_S    = 3'd3,
    CMD_ADD_SECS = 3'd4,
    CMD_CLR_ALL  = 3'd5,
    CMD_CLR_HUND = 3'd6
  } cmd_t;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_SHOW_HUND = 3'd0,
    REG_AL_HOURS  = 3'd1,
    REG_AL_MINS   = 3'd2,
    REG_AL_SECS   = 3'd3,
    REG_AL_HUND   = 3'd4
  } reg_idx_t;

  localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
  localparam logic [16:0] SECS_PER_HOUR = 17'd3600;
  localparam logic [16:0] SECS_PER_MIN  = 17'd60;

  localparam logic [7:0] ASCII_ZERO  = 8'h30;
  localparam logic [7:0] ASCII_COLON = 8'h3A;
  localparam logic [7:0] ASCII_DOT   = 8'h2E;
  localparam logic [7:0] ASCII_SPACE = 8'h20;

  // controller to datapath
  typedef struct packed {
    logic apply;      // run a tick, advance or clear command on the time
    logic start_add;  // load the reduced second count
    logic step_add;   // one hour, minute or second step of an add
    logic capture;    // load the output word
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic rem_zero;
  } dp_sts_t;

  // two ASCII digits of a value below 100; tens by reciprocal multiply
  function automatic logic [15:0] two_digits(input logic [6:0] v);
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [6:0]  units;
    prod  = 15'(v) * 15'd205;
    tens  = prod[14:11];
    units = v - 7'(7'(tens) * 7'd10);
    return {ASCII_ZERO + 8'(tens), ASCII_ZERO + 8'(units)};
  endfunction

endpackage

>>> rtl/tdc_ctrl.sv
// control state machine for the time-of-day counter
`timescale 1ns / 1ps

module tdc_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [2:0]       cmd,
  output logic             out_valid,
  input  logic             out_ready,
  output tdc_pkg::dp_cmd_t dp_cmd,
  input  tdc_pkg::dp_sts_t dp_sts
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_ADD  = 2'b10
  } state_t;

  state_t state, state_next;
  logic   accept;
  logic   is_add;

  assign in_ready = (state == S_IDLE) && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;
  assign is_add   = (cmd == tdc_pkg::CMD_ADD_SECS);

  always_comb begin
    state_next = state;
    dp_cmd     = '0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (is_add) begin
            dp_cmd.start_add = 1'b1;
            state_next       = S_ADD;
          end else begin
            dp_cmd.apply   = 1'b1;
            dp_cmd.capture = 1'b1;
          end
        end
      end
      S_ADD: begin
        if (dp_sts.rem_zero) begin
          dp_cmd.capture = 1'b1;
          state_next     = S_IDLE;
        end else begin
          dp_cmd.step_add = 1'b1;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (dp_cmd.capture) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

>>> rtl/tdc_dp.sv
// time registers, add-seconds counter and output word of the time-of-day counter
`timescale 1ns / 1ps

module tdc_dp (
  input  logic             clk,
  input  logic             rst,
  input  logic [2:0]       cmd,
  input  logic [16:0]      seconds_to_add,
  input  tdc_pkg::dp_cmd_t dp_cmd,
  output tdc_pkg::dp_sts_t dp_sts,
  input  logic             show_hundredths,
  input  logic [4:0]       alarm_hours,
  input  logic [5:0]       alarm_minutes,
  input  logic [5:0]       alarm_seconds,
  input  logic [6:0]       alarm_hundredths,
  output logic [4:0]       cur_hours,
  output logic [5:0]       cur_minutes,
  output logic [5:0]       cur_seconds,
  output logic [6:0]       cur_hundredths,
  output logic             second_carry,
  output logic             time_match,
  output logic [63:0]      text_hms,
  output logic [23:0]      text_fraction
);

  logic [4:0]  hours, hours_next;
  logic [5:0]  minutes, minutes_next;
  logic [5:0]  seconds, seconds_next;
  logic [6:0]  hundredths, hundredths_next;
  logic [16:0] add_remaining, add_remaining_next;
  logic        carry_next;

  logic        h_last, m_last, s_last, c_last;
  logic [4:0]  h_inc;
  logic [5:0]  m_inc, s_inc;
  logic [6:0]  c_inc;

  assign h_last = (hours == 5'd23);
  assign m_last = (minutes == 6'd59);
  assign s_last = (seconds == 6'd59);
  assign c_last = (hundredths == 7'd99);
  assign h_inc  = h_last ? 5'd0 : hours + 5'd1;
  assign m_inc  = m_last ? 6'd0 : minutes + 6'd1;
  assign s_inc  = s_last ? 6'd0 : seconds + 6'd1;
  assign c_inc  = c_last ? 7'd0 : hundredths + 7'd1;

  assign dp_sts.rem_zero = (add_remaining == 17'd0);

  always_comb begin
    hours_next         = hours;
    minutes_next       = minutes;
    seconds_next       = seconds;
    hundredths_next    = hundredths;
    add_remaining_next = add_remaining;
    carry_next         = 1'b0;
    if (dp_cmd.apply) begin
      case (tdc_pkg::cmd_t'(cmd))
        tdc_pkg::CMD_TICK: begin
          hundredths_next = c_inc;
          if (c_last) begin
            carry_next   = 1'b1;
            seconds_next = s_inc;
            if (s_last) begin
              minutes_next = m_inc;
              if (m_last) begin
                hours_next = h_inc;
              end
            end
          end
        end
        tdc_pkg::CMD_ADV_H: hours_next   = h_inc;
        tdc_pkg::CMD_ADV_M: minutes_next = m_inc;
        tdc_pkg::CMD_ADV_S: seconds_next = s_inc;
        tdc_pkg::CMD_CLR_ALL: begin
          hours_next      = 5'd0;
          minutes_next    = 6'd0;
          seconds_next    = 6'd0;
          hundredths_next = 7'd0;
        end
        tdc_pkg::CMD_CLR_HUND: hundredths_next = 7'd0;
        default: ;
      endcase
    end
    if (dp_cmd.start_add) begin
      // count is below two days, one subtract brings it under a day
      add_remaining_next = (seconds_to_add >= tdc_pkg::SECS_PER_DAY)
                         ? seconds_to_add - tdc_pkg::SECS_PER_DAY : seconds_to_add;
    end
    if (dp_cmd.step_add) begin
      if (add_remaining >= tdc_pkg::SECS_PER_HOUR) begin
        hours_next         = h_inc;
        add_remaining_next = add_remaining - tdc_pkg::SECS_PER_HOUR;
      end else if (add_remaining >= tdc_pkg::SECS_PER_MIN) begin
        minutes_next = m_inc;
        if (m_last) begin
          hours_next = h_inc;
        end
        add_remaining_next = add_remaining - tdc_pkg::SECS_PER_MIN;
      end else begin
        seconds_next = s_inc;
        if (s_last) begin
          minutes_next = m_inc;
          if (m_last) begin
            hours_next = h_inc;
          end
        end
        add_remaining_next = add_remaining - 17'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hours         <= 5'd0;
      minutes       <= 6'd0;
      seconds       <= 6'd0;
      hundredths    <= 7'd0;
      add_remaining <= 17'd0;
    end else begin
      hours         <= hours_next;
      minutes       <= minutes_next;
      seconds       <= seconds_next;
      hundredths    <= hundredths_next;
      add_remaining <= add_remaining_next;
    end
  end

  // output word, loaded from the updated time
  always_ff @(posedge clk) begin
    if (dp_cmd.capture) begin
      cur_hours      <= hours_next;
      cur_minutes    <= minutes_next;
      cur_seconds    <= seconds_next;
      cur_hundredths <= hundredths_next;
      second_carry   <= carry_next;
      time_match     <= (hours_next == alarm_hours) && (minutes_next == alarm_minutes)
                     && (seconds_next == alarm_seconds)
                     && (hundredths_next == alarm_hundredths);
      text_hms       <= {tdc_pkg::two_digits(7'(hours_next)), tdc_pkg::ASCII_COLON,
                         tdc_pkg::two_digits(7'(minutes_next)), tdc_pkg::ASCII_COLON,
                         tdc_pkg::two_digits(7'(seconds_next))};
      text_fraction  <= show_hundredths
                      ? {tdc_pkg::ASCII_DOT, tdc_pkg::two_digits(hundredths_next)}
                      : {tdc_pkg::ASCII_SPACE, tdc_pkg::ASCII_SPACE, tdc_pkg::ASCII_SPACE};
    end
  end

endmodule

>>> rtl/time_of_day_counter_hundredths.sv
// top level of the 24-hour time-of-day counter with hundredths
// a tick, advance or clear word shows its result in the cycle after acceptance
// throughput: one such word per cycle while the result side keeps taking words
// an add-seconds word reduces its count below one day, then runs k steps, k = hour steps
//   + minute steps + second steps (k at most 23 + 59 + 59); one shared step unit
// reset (rst, synchronous): time zero, compare time zero, hundredths shown, no word held
`timescale 1ns / 1ps

module time_of_day_counter_hundredths (
  input  logic        clk,
  input  logic        rst,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  cmd,
  input  logic [16:0] seconds_to_add,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [4:0]  cur_hours,
  output logic [5:0]  cur_minutes,
  output logic [5:0]  cur_seconds,
  output logic [6:0]  cur_hundredths,
  output logic        second_carry,
  output logic        time_match,
  output logic [63:0] text_hms,
  output logic [23:0] text_fraction,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  tdc_pkg::dp_cmd_t dp_cmd;
  tdc_pkg::dp_sts_t dp_sts;

  // configuration registers
  logic       show_hundredths;
  logic [4:0] alarm_hours;
  logic [5:0] alarm_minutes;
  logic [5:0] alarm_seconds;
  logic [6:0] alarm_hundredths;
  logic       cfg_write;
  logic [2:0] reg_idx;

  // no wait states on the register port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  // registers sit on 32-bit word addresses
  assign reg_idx   = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      show_hundredths  <= 1'b1;
      alarm_hours      <= 5'd0;
      alarm_minutes    <= 6'd0;
      alarm_seconds    <= 6'd0;
      alarm_hundredths <= 7'd0;
    end else if (cfg_write) begin
      case (tdc_pkg::reg_idx_t'(reg_idx))
        tdc_pkg::REG_SHOW_HUND: show_hundredths  <= pwdata[0];
        tdc_pkg::REG_AL_HOURS:  alarm_hours      <= pwdata[4:0];
        tdc_pkg::REG_AL_MINS:   alarm_minutes    <= pwdata[5:0];
        tdc_pkg::REG_AL_SECS:   alarm_seconds    <= pwdata[5:0];
        tdc_pkg::REG_AL_HUND:   alarm_hundredths <= pwdata[6:0];
        default: ;  // addresses past the register list are ignored
      endcase
    end
  end

  // read back
  always_comb begin
    case (tdc_pkg::reg_idx_t'(reg_idx))
      tdc_pkg::REG_SHOW_HUND: prdata = {31'd0, show_hundredths};
      tdc_pkg::REG_AL_HOURS:  prdata = {27'd0, alarm_hours};
      tdc_pkg::REG_AL_MINS:   prdata = {26'd0, alarm_minutes};
      tdc_pkg::REG_AL_SECS:   prdata = {26'd0, alarm_seconds};
      tdc_pkg::REG_AL_HUND:   prdata = {25'd0, alarm_hundredths};
      default:                prdata = 32'd0;
    endcase
  end

  // sequencing: accepts a word, runs the add steps, loads the result word
  tdc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .dp_cmd    (dp_cmd),
    .dp_sts    (dp_sts)
  );

  // time registers, step unit and output word
  tdc_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .seconds_to_add   (seconds_to_add),
    .dp_cmd           (dp_cmd),
    .dp_sts           (dp_sts),
    .show_hundredths  (show_hundredths),
    .alarm_hours      (alarm_hours),
    .alarm_minutes    (alarm_minutes),
    .alarm_seconds    (alarm_seconds),
    .alarm_hundredths (alarm_hundredths),
    .cur_hours        (cur_hours),
    .cur_minutes      (cur_minutes),
    .cur_seconds      (cur_seconds),
    .cur_hundredths   (cur_hundredths),
    .second_carry     (second_carry),
    .time_match       (time_match),
    .text_hms         (text_hms),
    .text_fraction    (text_fraction)
  );

`ifndef SYNTHESIS
  // a reported time is always a legal time of day
  a_time_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (cur_hours < 5'd24) && (cur_minutes < 6'd60)
               && (cur_seconds < 6'd60) && (cur_hundredths < 7'd100))
    else $error("reported time out of range");

  // a second rollover leaves hundredths at zero
  a_carry_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && second_carry) |-> (cur_hundredths == 7'd0))
    else $error("second carry with nonzero hundredths");

  // a tick, advance or clear command shows its result on the next cycle
  a_short_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && (cmd != tdc_pkg::CMD_ADD_SECS)) |=> out_valid)
    else $error("result missing after one-cycle command");

  // nothing is taken while an add is running
  a_add_blocks: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && (cmd == tdc_pkg::CMD_ADD_SECS)) |=> !in_ready)
    else $error("input taken during add");
`endif

endmodule
